FILE: rtl/core/psd_pkg.sv
// Shared types and constants for the point-to-segment distance block.
package psd_pkg;

  localparam int MAX_DIM   = 16;
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int ACC_W     = 40;
  localparam int DIST_W    = 27;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1) + 1;
  localparam int FRAC_SH   = 16;
  localparam int NN_W      = 39;
  localparam int SQ_W      = 2 * NN_W;
  localparam int DIVD_W    = SQ_W + FRAC_SH;
  localparam int QUO_W     = 55;
  localparam int RAD_W     = 2 * DIST_W;
  localparam int SREM_W    = DIST_W + 1;
  localparam int MUL_STEPS  = NN_W;
  // The dividend's top bit is loaded straight into the remainder.
  localparam int DIV_STEPS  = DIVD_W - 1;
  localparam int SQRT_STEPS = DIST_W;
  localparam int STEP_W     = 7;

  typedef struct packed {
    logic signed [ACC_W-1:0] n;
    logic [ACC_W-1:0]        d;
    logic [ACC_W-1:0]        sa;
    logic [ACC_W-1:0]        sb;
    logic                    ovf;
  } psd_job_t;

endpackage

FILE: rtl/core/psd_ifs.sv
// Handshake channel interfaces for coordinate items and distance results.
interface psd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [psd_pkg::COORD_W-1:0]    point_coord;
  logic signed [psd_pkg::COORD_W-1:0]    start_coord;
  logic signed [psd_pkg::COORD_W-1:0]    end_coord;
  logic                                  last;
  modport source (output valid, point_coord, start_coord, end_coord, last, input ready);
  modport sink   (input valid, point_coord, start_coord, end_coord, last, output ready);
endinterface

interface psd_out_if;
  logic                          valid;
  logic                          ready;
  logic [psd_pkg::DIST_W-1:0]    distance;
  logic                          on_segment;
  logic                          too_many;
  modport source (output valid, distance, on_segment, too_many, input ready);
  modport sink   (input valid, distance, on_segment, too_many, output ready);
endinterface

FILE: rtl/core/point_segment_distance.sv
// Top level of the point-to-segment distance block.
// The block returns floor(256 * distance) from a point to a line segment in up to
// sixteen dimensions. Each input transfer carries one coordinate of the point, the
// segment start and the segment end; the transfer marked last closes the point and
// produces exactly one result transfer, carrying the distance with eight fraction
// bits, whether the projection fell on the segment, and whether more than sixteen
// coordinates arrived (extra coordinates are ignored). Coordinates are taken one per
// cycle, while the queue has room, by a three-stage accumulating front end. Finished
// sums wait in a four-entry queue for the back end, which works on one point at a
// time: a point off the segment (or with a zero-length segment) goes straight to a
// 27-step square root, while a point on the segment first passes through a bit-serial
// 39-step squaring, a restoring division and the forming of the radicand. The result
// is held in an output register until it is taken, while the front end keeps
// accepting coordinates as long as the queue has room.
module point_segment_distance (
  input  logic clk,
  input  logic rst_n,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch
);
  logic                        push, pop, job_valid;
  psd_pkg::psd_job_t           push_job, job;
  logic [psd_pkg::QCNT_W-1:0]  q_occ;

  // Accumulates the projection numerator, the segment length squared and both endpoint
  // distances squared, one coordinate per cycle while the queue has room.
  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_occ    (q_occ),
    .push     (push),
    .push_job (push_job)
  );

  // Decouples the two sides so that each stalls on its own.
  psd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job),
    .occ       (q_occ)
  );

  // Chooses the branch and runs the iterative arithmetic.
  psd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .out_ch    (out_ch)
  );
endmodule

FILE: rtl/core/psd_queue.sv
// Small job queue between the accumulating front and the iterative back.
module psd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psd_pkg::psd_job_t  push_job,
  input  logic               pop,
  output logic               job_valid,
  output psd_pkg::psd_job_t  job,
  output logic [psd_pkg::QCNT_W-1:0] occ
);
  psd_pkg::psd_job_t mem_r [psd_pkg::QDEPTH];
  logic [psd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [psd_pkg::QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign job_valid = (cnt_r != '0);
  assign job       = mem_r[rd_ptr_r];
  assign occ       = cnt_r;
endmodule

FILE: rtl/core/psd_front.sv
// Front end: takes coordinate items, forms products and accumulates the four sums.
module psd_front (
  input  logic               clk,
  input  logic               rst_n,
  psd_in_if.sink             in_ch,
  input  logic [psd_pkg::QCNT_W-1:0] q_occ,
  output logic               push,
  output psd_pkg::psd_job_t  push_job
);
  logic [psd_pkg::CNT_W-1:0] count_r;
  logic ovf_r;
  logic take, full;

  logic s1_v_r, s1_en_r, s1_last_r, s1_ovf_r;
  logic signed [psd_pkg::DIFF_W-1:0] s1_m_r, s1_xa_r, s1_bx_r;

  logic s2_v_r, s2_last_r, s2_ovf_r;
  logic signed [psd_pkg::PROD_W-1:0] s2_n_r, s2_d_r, s2_a_r, s2_b_r;

  logic signed [psd_pkg::ACC_W-1:0] acc_n_r, sum_n;
  logic [psd_pkg::ACC_W-1:0] acc_d_r, acc_a_r, acc_b_r, sum_d, sum_a, sum_b;
  logic [psd_pkg::QCNT_W-1:0] pending;

  // Every last item in flight must find a free queue slot.
  assign pending = q_occ + psd_pkg::QCNT_W'(s1_v_r & s1_last_r)
                         + psd_pkg::QCNT_W'(s2_v_r & s2_last_r);
  assign in_ch.ready = (pending < psd_pkg::QCNT_W'(psd_pkg::QDEPTH));
  assign take = in_ch.valid & in_ch.ready;
  assign full = (count_r >= psd_pkg::CNT_W'(psd_pkg::MAX_DIM));

  assign sum_n = acc_n_r + psd_pkg::ACC_W'(s2_n_r);
  assign sum_d = acc_d_r + psd_pkg::ACC_W'(s2_d_r);
  assign sum_a = acc_a_r + psd_pkg::ACC_W'(s2_a_r);
  assign sum_b = acc_b_r + psd_pkg::ACC_W'(s2_b_r);

  assign push = s2_v_r & s2_last_r;
  always_comb begin
    push_job.n   = sum_n;
    push_job.d   = sum_d;
    push_job.sa  = sum_a;
    push_job.sb  = sum_b;
    push_job.ovf = s2_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_m_r    <= psd_pkg::DIFF_W'(in_ch.end_coord) - psd_pkg::DIFF_W'(in_ch.start_coord);
      s1_xa_r   <= psd_pkg::DIFF_W'(in_ch.point_coord) - psd_pkg::DIFF_W'(in_ch.start_coord);
      s1_bx_r   <= psd_pkg::DIFF_W'(in_ch.end_coord) - psd_pkg::DIFF_W'(in_ch.point_coord);
      s1_en_r   <= !full;
      s1_last_r <= in_ch.last;
      s1_ovf_r  <= ovf_r | full;
    end
    if (s1_v_r) begin
      // The zero is signed so that the products stay signed.
      s2_n_r    <= s1_en_r ? s1_m_r * s1_xa_r : $signed(psd_pkg::PROD_W'(0));
      s2_d_r    <= s1_en_r ? s1_m_r * s1_m_r : $signed(psd_pkg::PROD_W'(0));
      s2_a_r    <= s1_en_r ? s1_xa_r * s1_xa_r : $signed(psd_pkg::PROD_W'(0));
      s2_b_r    <= s1_en_r ? s1_bx_r * s1_bx_r : $signed(psd_pkg::PROD_W'(0));
      s2_last_r <= s1_last_r;
      s2_ovf_r  <= s1_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      acc_n_r <= '0;
      acc_d_r <= '0;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      if (take) begin
        if (in_ch.last) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (s2_v_r) begin
        if (s2_last_r) begin
          acc_n_r <= '0;
          acc_d_r <= '0;
          acc_a_r <= '0;
          acc_b_r <= '0;
        end else begin
          acc_n_r <= sum_n;
          acc_d_r <= sum_d;
          acc_a_r <= sum_a;
          acc_b_r <= sum_b;
        end
      end
    end
  end
endmodule

FILE: rtl/core/psd_back.sv
// Back end: iterative square, division and square root producing one distance per job.
module psd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  psd_pkg::psd_job_t  job,
  output logic               pop,
  psd_out_if.source          out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIX, S_SQRT, S_DONE} state_t;
  state_t state_r;

  logic [psd_pkg::STEP_W-1:0] step_r;
  logic [psd_pkg::NN_W-1:0]   nn_r;
  logic [psd_pkg::ACC_W-1:0]  d_r, sa_r;
  logic [psd_pkg::SQ_W-1:0]   prod_r;
  logic [psd_pkg::DIVD_W-1:0] dv_r;
  logic [psd_pkg::NN_W-1:0]   rem_r;
  logic [psd_pkg::QUO_W-1:0]  quo_r;
  logic [psd_pkg::RAD_W-1:0]  rad_r;
  logic [psd_pkg::SREM_W-1:0] srem_r;
  logic [psd_pkg::DIST_W-1:0] root_r;
  logic onseg_r, ovf_r, out_valid_r;

  logic job_onseg;
  logic [psd_pkg::ACC_W-1:0]   min_ab;
  logic [psd_pkg::NN_W:0]      msum;
  logic [psd_pkg::NN_W:0]      dtrial;
  logic [psd_pkg::QUO_W:0]     sub, base;
  logic [psd_pkg::SREM_W+1:0]  rm, strial;

  assign job_onseg = (job.d != '0) && !job.n[psd_pkg::ACC_W-1] &&
                     ($unsigned(job.n) <= job.d);
  assign min_ab = (job.sa < job.sb) ? job.sa : job.sb;

  // Shift-add multiplier step (multiplier in the low half of prod_r).
  assign msum = {1'b0, prod_r[psd_pkg::SQ_W-1:psd_pkg::NN_W]} +
                (prod_r[0] ? {1'b0, nn_r} : '0);
  // Restoring division step.
  assign dtrial = {rem_r, dv_r[psd_pkg::DIVD_W-1]};
  // Ceiling of the quotient, subtracted from the scaled start distance.
  assign sub  = {1'b0, quo_r} + psd_pkg::QUO_W'(rem_r != '0);
  assign base = (psd_pkg::QUO_W+1)'({sa_r, {psd_pkg::FRAC_SH{1'b0}}});
  // Digit-by-digit square root step.
  assign rm     = {srem_r, rad_r[psd_pkg::RAD_W-1 -: 2]};
  assign strial = {1'b0, root_r, 2'b01};

  assign pop = (state_r == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            onseg_r <= job_onseg;
            ovf_r   <= job.ovf;
            d_r     <= job.d;
            sa_r    <= job.sa;
            // Off the segment nn_r must not look like the radicand marker.
            nn_r    <= job_onseg ? job.n[psd_pkg::NN_W-1:0] : '0;
            prod_r  <= psd_pkg::SQ_W'(job.n[psd_pkg::NN_W-1:0]);
            rad_r   <= psd_pkg::RAD_W'({min_ab, {psd_pkg::FRAC_SH{1'b0}}});
            srem_r  <= '0;
            root_r  <= '0;
            if (job_onseg) begin
              step_r  <= psd_pkg::STEP_W'(psd_pkg::MUL_STEPS - 1);
              state_r <= S_MUL;
            end else begin
              step_r  <= psd_pkg::STEP_W'(psd_pkg::SQRT_STEPS - 1);
              state_r <= S_SQRT;
            end
          end
        end
        S_MUL: begin
          prod_r <= {msum, prod_r[psd_pkg::NN_W-1:1]};
          if (step_r == '0) begin
            step_r  <= psd_pkg::STEP_W'(psd_pkg::DIV_STEPS - 1);
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_DIV: begin
          if (step_r == psd_pkg::STEP_W'(psd_pkg::DIV_STEPS - 1)) begin
            dv_r <= {prod_r[psd_pkg::SQ_W-2:0], {psd_pkg::FRAC_SH{1'b0}}, 1'b0};
            rem_r <= psd_pkg::NN_W'(prod_r[psd_pkg::SQ_W-1]);
          end else begin
            dv_r <= {dv_r[psd_pkg::DIVD_W-2:0], 1'b0};
            if (dtrial >= d_r[psd_pkg::NN_W:0]) begin
              rem_r <= psd_pkg::NN_W'(dtrial - d_r[psd_pkg::NN_W:0]);
              quo_r <= {quo_r[psd_pkg::QUO_W-2:0], 1'b1};
            end else begin
              rem_r <= dtrial[psd_pkg::NN_W-1:0];
              quo_r <= {quo_r[psd_pkg::QUO_W-2:0], 1'b0};
            end
          end
          if (step_r == '0) begin
            state_r <= S_FIX;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_FIX: begin
          // Last quotient bit, taken from the bit still waiting in dv_r.
          if (dtrial >= d_r[psd_pkg::NN_W:0]) begin
            rem_r <= psd_pkg::NN_W'(dtrial - d_r[psd_pkg::NN_W:0]);
            quo_r <= {quo_r[psd_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_r <= dtrial[psd_pkg::NN_W-1:0];
            quo_r <= {quo_r[psd_pkg::QUO_W-2:0], 1'b0};
          end
          out_valid_r <= 1'b0;
          step_r  <= psd_pkg::STEP_W'(psd_pkg::SQRT_STEPS - 1);
          state_r <= S_SQRT;
          rad_r   <= '0;
          onseg_r <= 1'b1;
          ovf_r   <= ovf_r;
          sa_r    <= sa_r;
          root_r  <= '0;
          srem_r  <= '0;
          nn_r    <= '1;
        end
        S_SQRT: begin
          if (nn_r == '1) begin
            // First cycle after the division: form the radicand.
            nn_r  <= '0;
            rad_r <= (base >= sub) ? psd_pkg::RAD_W'(base - sub) : '0;
          end else begin
            rad_r <= {rad_r[psd_pkg::RAD_W-3:0], 2'b00};
            if (rm >= strial) begin
              srem_r <= psd_pkg::SREM_W'(rm - strial);
              root_r <= {root_r[psd_pkg::DIST_W-2:0], 1'b1};
            end else begin
              srem_r <= rm[psd_pkg::SREM_W-1:0];
              root_r <= {root_r[psd_pkg::DIST_W-2:0], 1'b0};
            end
            if (step_r == '0) begin
              out_valid_r <= 1'b1;
              state_r     <= S_DONE;
            end else begin
              step_r <= step_r - 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.distance   = root_r;
  assign out_ch.on_segment = onseg_r;
  assign out_ch.too_many   = ovf_r;
endmodule

FILE: rtl/core/psd_checker.sv
// Port-level assertions for the point-to-segment distance block, with its bind.
module psd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [psd_pkg::DIST_W-1:0]  out_distance,
  input logic                        out_on_segment,
  input logic                        out_too_many
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_on_segment)
                                && $stable(out_too_many))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");
endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_distance   (out_ch.distance),
  .out_on_segment (out_ch.on_segment),
  .out_too_many   (out_ch.too_many)
);
